/* rtl/rsq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rsq_pkg;

    // coordinate and table geometry
    localparam int COORD_FRAC_BITS    = 4;
    localparam int TRIG_TABLE_ENTRIES = 1024;
    localparam int TRIG_IDX_W         = $clog2(TRIG_TABLE_ENTRIES + 1);
    localparam int TRIG_ADDR_W        = $clog2(TRIG_TABLE_ENTRIES);
    localparam int SINE_W             = 15;
    localparam int PAIR_W             = 2 * SINE_W;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 14;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_W = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_H = 8'd3;

    // corner codes
    localparam logic [1:0] CORNER_BR = 2'd3;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic signed [15:0] dest_x;
        logic signed [15:0] dest_y;
        logic signed [15:0] dest_w;
        logic signed [15:0] dest_h;
        logic signed [15:0] src_x;
        logic signed [15:0] src_y;
        logic signed [15:0] src_w;
        logic signed [15:0] src_h;
        logic signed [15:0] angle;
    } req_t;

    typedef struct packed {
        logic [1:0]         corner;
        logic               last;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] tex_u;
        logic signed [15:0] tex_v;
    } vtx_t;

    // word i holds {sin entry i+1, sin entry i}
    typedef logic [TRIG_TABLE_ENTRIES-1:0][PAIR_W-1:0] pair_tab_t;

    // quarter-wave sine in Q14, series in Q30, evaluated at elaboration
    function automatic pair_tab_t build_pairs();
        logic [TRIG_TABLE_ENTRIES:0][SINE_W-1:0] tab;
        pair_tab_t          pairs;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        rounded;
        for (int i = 0; i <= TRIG_TABLE_ENTRIES; i++)
        begin
            x    = (HALF_PI_Q30 * 64'(i)) / TRIG_TABLE_ENTRIES;
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            term = ((term * x2) >> 30) / 64'd6;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd156;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd210;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd272;
            sum  = sum + $signed(term);
            if (sum < 0)
            begin
                sum = 0;
            end
            rounded = ($unsigned(sum) + 64'd32768) >> 16;
            tab[i]  = rounded[SINE_W-1:0];
        end
        for (int i = 0; i < TRIG_TABLE_ENTRIES; i++)
        begin
            pairs[i] = {tab[i+1], tab[i]};
        end
        return pairs;
    endfunction

endpackage

`default_nettype wire

/* rtl/rotated_sprite_quad_setup.sv */
`timescale 1ns / 1ps
`default_nettype none

// Rotated sprite quad setup. Each accepted request (destination rectangle,
// source rectangle, angle in 1/16 degree) yields four vertices, top-left,
// top-right, bottom-left, bottom-right, with device positions in Q2.14 and
// texture coordinates in Q4.12, all saturated. Vertices are produced one per
// cycle when the output is not stalled; the next request is taken while the
// previous one issues its last vertex. The rate is set by the single vertex
// channel: a request is held at the front and fed into the pipeline as four
// vertex items. From issue to output a vertex passes through the angle
// reduction, the registered sine ROM and the four restoring dividers that
// retire one quotient bit per stage. The sine ROM is a constant table and
// needs no fill after reset. Configuration writes are always ready and must
// be made while the block is idle; a size register of zero acts as one.
module rotated_sprite_quad_setup
(
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                req_valid,
    output logic                               req_stall,
    input  rsq_pkg::req_t                      req_data,
    output logic                               vtx_valid,
    input  wire                                vtx_stall,
    output rsq_pkg::vtx_t                      vtx_data,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [rsq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [rsq_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int F        = rsq_pkg::COORD_FRAC_BITS;
    localparam int ENT      = rsq_pkg::TRIG_TABLE_ENTRIES;
    localparam int IDX_W    = rsq_pkg::TRIG_IDX_W;
    localparam int ADDR_W   = rsq_pkg::TRIG_ADDR_W;
    localparam int SW       = rsq_pkg::SINE_W;
    localparam int PW       = rsq_pkg::PAIR_W;
    localparam int SZ_W     = rsq_pkg::CFG_DATA_W;
    localparam int DD_W     = SZ_W + F + 1;
    localparam int NW       = (DD_W + 19 > 38) ? DD_W + 19 : 38;

    localparam int TURN     = 5760;
    localparam int QUARTER  = 1440;
    localparam int ANG_BIAS = 6 * TURN;
    localparam int RT_SH    = 28;
    localparam int RT       = (1 << RT_SH) / TURN;
    localparam int RQ_SH    = 36;
    localparam longint RQ   = (longint'(1) << RQ_SH) / QUARTER;
    localparam int ONE_SH   = 14;
    localparam int ONE_Q14  = 1 << ONE_SH;
    localparam int TEX_SH   = 13;
    localparam int P_W      = $clog2(QUARTER * ENT + 1);
    localparam int PR_W     = P_W + 27;
    localparam int NUM_W    = 27;
    localparam int NUMP_W   = NUM_W + 27;
    localparam int INTERP_BIAS = QUARTER * ONE_Q14;

    localparam int DIV_BITS = 17;
    localparam int DIV0     = 15;
    localparam int NST      = DIV0 + DIV_BITS + 1;
    localparam int LAST     = NST - 1;

    localparam logic [PW-1:0] ROM_UNUSED = '0;
    localparam rsq_pkg::pair_tab_t PAIR_TAB = rsq_pkg::build_pairs();

    typedef struct packed {
        logic [1:0]         corner;
        logic signed [16:0] ox;
        logic signed [16:0] oy;
        logic signed [17:0] cx2;
        logic signed [17:0] cy2;
        logic signed [16:0] nu;
        logic signed [16:0] nv;
    } ctx_t;

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sd32767)
        begin
            r = 16'sh7fff;
        end
        else if (v < -20'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    // configuration registers
    logic [SZ_W-1:0] scr_w_reg;
    logic [SZ_W-1:0] scr_h_reg;
    logic [SZ_W-1:0] tex_w_reg;
    logic [SZ_W-1:0] tex_h_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_w_reg <= 14'd1280;
            scr_h_reg <= 14'd720;
            tex_w_reg <= 14'd256;
            tex_h_reg <= 14'd256;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rsq_pkg::REG_SCREEN_W:  scr_w_reg <= cfg_data;
                rsq_pkg::REG_SCREEN_H:  scr_h_reg <= cfg_data;
                rsq_pkg::REG_TEXTURE_W: tex_w_reg <= cfg_data;
                rsq_pkg::REG_TEXTURE_H: tex_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // divisor per lane: 0 pos_x, 1 pos_y, 2 tex_u, 3 tex_v
    logic [SZ_W-1:0]        sz   [4];
    logic [DD_W-1:0]        dn   [4];
    logic [DD_W-1:0]        dd   [4];

    always_comb
    begin
        sz[0] = (scr_w_reg == '0) ? SZ_W'(1) : scr_w_reg;
        sz[1] = (scr_h_reg == '0) ? SZ_W'(1) : scr_h_reg;
        sz[2] = (tex_w_reg == '0) ? SZ_W'(1) : tex_w_reg;
        sz[3] = (tex_h_reg == '0) ? SZ_W'(1) : tex_h_reg;
        for (int l = 0; l < 4; l++)
        begin
            dn[l] = DD_W'(sz[l]) << F;
            dd[l] = DD_W'(sz[l]) << (F + 1);
        end
    end

    // pipeline enable: everything moves unless the output is held
    logic en;
    logic out_valid_reg;
    rsq_pkg::vtx_t out_data_reg;

    assign en = !(out_valid_reg && vtx_stall);

    // request holding stage, issues four vertex items
    logic          hold_reg;
    logic [1:0]    k_reg;
    rsq_pkg::req_t item_reg;
    logic          issue;
    logic          accept;

    assign issue     = hold_reg && en;
    assign req_stall = hold_reg && !(en && k_reg == rsq_pkg::CORNER_BR);
    assign accept    = req_valid && !req_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= 1'b0;
            k_reg    <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                hold_reg <= 1'b1;
            end
            else if (issue && k_reg == rsq_pkg::CORNER_BR)
            begin
                hold_reg <= 1'b0;
            end
            if (issue)
            begin
                k_reg <= k_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req_data;
        end
    end

    // vertex context, valid bits travel with it
    logic [NST-1:0] vld_reg;
    ctx_t           ctx_reg [NST];
    ctx_t           ctx_in;

    always_comb
    begin
        ctx_in.corner = k_reg;
        ctx_in.ox  = k_reg[0] ? 17'(item_reg.dest_w) : -17'(item_reg.dest_w);
        ctx_in.oy  = k_reg[1] ? 17'(item_reg.dest_h) : -17'(item_reg.dest_h);
        ctx_in.cx2 = (18'(item_reg.dest_x) <<< 1) + 18'(item_reg.dest_w);
        ctx_in.cy2 = (18'(item_reg.dest_y) <<< 1) + 18'(item_reg.dest_h);
        ctx_in.nu  = 17'(item_reg.src_x) + (k_reg[0] ? 17'(item_reg.src_w) : 17'sd0);
        ctx_in.nv  = 17'(item_reg.src_y) + (k_reg[1] ? 17'(item_reg.src_h) : 17'sd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], issue};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg[0] <= ctx_in;
            for (int i = 1; i < NST; i++)
            begin
                ctx_reg[i] <= ctx_reg[i-1];
            end
        end
    end

    // angle reduction, quadrant split and table position
    logic signed [17:0] ang_ext;
    logic [16:0]        n1_reg;
    logic [16:0]        n2_reg;
    logic [3:0]         qt2_reg;
    logic [32:0]        qt_prod;
    logic [16:0]        turn_rem;
    logic [12:0]        a3_reg;
    logic [1:0]         quad_next;
    logic [1:0]         quad4_reg;
    logic [1:0]         quad5_reg;
    logic [1:0]         quad6_reg;
    logic [1:0]         quad7_reg;
    logic [1:0]         quad8_reg;
    logic [1:0]         quad9_reg;
    logic [1:0]         quad10_reg;
    logic [1:0]         quad11_reg;
    logic [10:0]        r4_reg   [2];
    logic [P_W-1:0]     p5_reg   [2];
    logic [P_W-1:0]     p6_reg   [2];
    logic [IDX_W-1:0]   ie6_reg  [2];
    logic [IDX_W-1:0]   idx7_reg [2];
    logic [10:0]        fr7_reg  [2];
    logic               top7_reg [2];
    logic [PW-1:0]      rom8_reg [2];
    logic [10:0]        fr8_reg  [2];
    logic               top8_reg [2];
    logic [SW-1:0]      lo9_reg  [2];
    logic [SW-1:0]      hi9_reg  [2];
    logic [NUM_W-1:0]   num9_reg [2];
    logic               top9_reg [2];
    logic [SW-1:0]      lo10_reg [2];
    logic [SW-1:0]      hi10_reg [2];
    logic [NUM_W-1:0]   num10_reg[2];
    logic [16:0]        qe10_reg [2];
    logic               top10_reg[2];
    logic signed [15:0] t11_reg  [2];
    logic signed [15:0] sn12_reg;
    logic signed [15:0] cs12_reg;

    assign ang_ext = 18'(item_reg.angle) + 18'(ANG_BIAS);
    assign qt_prod = 33'(n1_reg) * 33'(RT);
    assign turn_rem = n2_reg - 17'(qt2_reg) * 17'(TURN);

    always_comb
    begin
        if (a3_reg >= 13'(3 * QUARTER))
        begin
            quad_next = 2'd3;
        end
        else if (a3_reg >= 13'(2 * QUARTER))
        begin
            quad_next = 2'd2;
        end
        else if (a3_reg >= 13'(QUARTER))
        begin
            quad_next = 2'd1;
        end
        else
        begin
            quad_next = 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg  <= ang_ext[16:0];
            n2_reg  <= n1_reg;
            qt2_reg <= 4'(qt_prod >> RT_SH);
            a3_reg  <= (turn_rem >= 17'(TURN)) ? 13'(turn_rem - 17'(TURN)) : 13'(turn_rem);
            quad4_reg <= quad_next;
            r4_reg[0] <= 11'(a3_reg - 13'(quad_next) * 13'(QUARTER));
            r4_reg[1] <= 11'(13'(QUARTER) - (a3_reg - 13'(quad_next) * 13'(QUARTER)));
            quad5_reg  <= quad4_reg;
            quad6_reg  <= quad5_reg;
            quad7_reg  <= quad6_reg;
            quad8_reg  <= quad7_reg;
            quad9_reg  <= quad8_reg;
            quad10_reg <= quad9_reg;
            quad11_reg <= quad10_reg;
        end
    end

    // per sine and cosine lane: table index, rom read, interpolation
    logic [PR_W-1:0]    ip_prod  [2];
    logic [P_W-1:0]     ip_rem   [2];
    logic [ADDR_W-1:0]  rom_addr [2];
    logic signed [15:0] diff     [2];
    logic signed [27:0] dprod    [2];
    logic signed [28:0] num_s    [2];
    logic [NUMP_W-1:0]  qe_prod  [2];
    logic [NUM_W-1:0]   qi_rem   [2];
    logic [16:0]        qi_fix   [2];
    logic signed [17:0] interp   [2];

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            ip_prod[l]  = PR_W'(p5_reg[l]) * PR_W'(RQ);
            ip_rem[l]   = p6_reg[l] - P_W'(ie6_reg[l]) * P_W'(QUARTER);
            rom_addr[l] = top7_reg[l] ? ADDR_W'(ENT - 1) : idx7_reg[l][ADDR_W-1:0];
            diff[l]     = $signed(16'(rom8_reg[l][PW-1:SW])) - $signed(16'(rom8_reg[l][SW-1:0]));
            dprod[l]    = 28'(diff[l]) * $signed(28'(fr8_reg[l]));
            num_s[l]    = 29'(dprod[l]) + 29'(QUARTER / 2) + 29'(INTERP_BIAS);
            qe_prod[l]  = NUMP_W'(num9_reg[l]) * NUMP_W'(RQ);
            qi_rem[l]   = num10_reg[l] - NUM_W'(qe10_reg[l]) * NUM_W'(QUARTER);
            qi_fix[l]   = (qi_rem[l] >= NUM_W'(QUARTER)) ? qe10_reg[l] + 17'd1 : qe10_reg[l];
            interp[l]   = $signed(18'(lo10_reg[l])) + $signed(18'(qi_fix[l])) - 18'sd16384;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 2; l++)
            begin
                p5_reg[l]    <= P_W'(r4_reg[l]) * P_W'(ENT);
                p6_reg[l]    <= p5_reg[l];
                ie6_reg[l]   <= IDX_W'(ip_prod[l] >> RQ_SH);
                if (ip_rem[l] >= P_W'(QUARTER))
                begin
                    idx7_reg[l] <= ie6_reg[l] + IDX_W'(1);
                    fr7_reg[l]  <= 11'(ip_rem[l] - P_W'(QUARTER));
                    top7_reg[l] <= (ie6_reg[l] + IDX_W'(1)) >= IDX_W'(ENT);
                end
                else
                begin
                    idx7_reg[l] <= ie6_reg[l];
                    fr7_reg[l]  <= 11'(ip_rem[l]);
                    top7_reg[l] <= ie6_reg[l] >= IDX_W'(ENT);
                end
                rom8_reg[l]  <= PAIR_TAB[rom_addr[l]] | ROM_UNUSED;
                fr8_reg[l]   <= fr7_reg[l];
                top8_reg[l]  <= top7_reg[l];
                lo9_reg[l]   <= rom8_reg[l][SW-1:0];
                hi9_reg[l]   <= rom8_reg[l][PW-1:SW];
                num9_reg[l]  <= NUM_W'(num_s[l]);
                top9_reg[l]  <= top8_reg[l];
                lo10_reg[l]  <= lo9_reg[l];
                hi10_reg[l]  <= hi9_reg[l];
                num10_reg[l] <= num9_reg[l];
                qe10_reg[l]  <= 17'(qe_prod[l] >> RQ_SH);
                top10_reg[l] <= top9_reg[l];
                t11_reg[l]   <= top10_reg[l] ? $signed(16'(hi10_reg[l])) : 16'(interp[l]);
            end
        end
    end

    // quadrant signs: lane 0 is sin of remainder, lane 1 is its cosine
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            case (quad11_reg)
                2'd0:
                begin
                    sn12_reg <= t11_reg[0];
                    cs12_reg <= t11_reg[1];
                end
                2'd1:
                begin
                    sn12_reg <= t11_reg[1];
                    cs12_reg <= -t11_reg[0];
                end
                2'd2:
                begin
                    sn12_reg <= -t11_reg[0];
                    cs12_reg <= -t11_reg[1];
                end
                default:
                begin
                    sn12_reg <= -t11_reg[1];
                    cs12_reg <= t11_reg[0];
                end
            endcase
        end
    end

    // rotation and divider numerators
    logic signed [32:0]   m13_reg [4];
    logic signed [33:0]   x14_reg;
    logic signed [33:0]   y14_reg;
    logic signed [NW-1:0] n15_reg [4];
    logic signed [NW-1:0] dn_s    [4];

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            dn_s[l] = $signed(NW'(dn[l]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m13_reg[0] <= 33'(cs12_reg) * 33'(ctx_reg[11].ox);
            m13_reg[1] <= 33'(sn12_reg) * 33'(ctx_reg[11].oy);
            m13_reg[2] <= 33'(sn12_reg) * 33'(ctx_reg[11].ox);
            m13_reg[3] <= 33'(cs12_reg) * 33'(ctx_reg[11].oy);
            x14_reg <= (34'(ctx_reg[12].cx2) <<< ONE_SH) + 34'(m13_reg[0]) - 34'(m13_reg[1]);
            y14_reg <= (34'(ctx_reg[12].cy2) <<< ONE_SH) + 34'(m13_reg[2]) + 34'(m13_reg[3]);
            n15_reg[0] <= (NW'(x14_reg) <<< 1) + dn_s[0];
            n15_reg[1] <= (NW'(y14_reg) <<< 1) + dn_s[1];
            n15_reg[2] <= (NW'(ctx_reg[13].nu) <<< TEX_SH) + dn_s[2];
            n15_reg[3] <= (NW'(ctx_reg[13].nv) <<< TEX_SH) + dn_s[3];
        end
    end

    // restoring dividers, quotient window [-32768, 65535], one bit per stage
    logic [NW-1:0]       rem_reg [DIV_BITS+1][4];
    logic [DIV_BITS-1:0] quo_reg [DIV_BITS+1][4];
    logic                los_reg [DIV_BITS+1][4];
    logic                his_reg [DIV_BITS+1][4];
    logic signed [NW-1:0] ddx15  [4];
    logic signed [NW-1:0] ddx16  [4];

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            ddx15[l] = $signed(NW'(dd[l]) << 15);
            ddx16[l] = $signed(NW'(dd[l]) << 16);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 4; l++)
            begin
                rem_reg[0][l] <= $unsigned(n15_reg[l] + ddx15[l]);
                quo_reg[0][l] <= '0;
                los_reg[0][l] <= n15_reg[l] < -ddx15[l];
                his_reg[0][l] <= n15_reg[l] >= ddx16[l];
            end
        end
    end

    for (genvar d = 1; d <= DIV_BITS; d++)
    begin : g_div
        localparam int B = DIV_BITS - d;
        for (genvar l = 0; l < 4; l++)
        begin : g_lane
            logic [NW-1:0] shifted;
            assign shifted = NW'(dd[l]) << B;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (rem_reg[d-1][l] >= shifted)
                    begin
                        rem_reg[d][l] <= rem_reg[d-1][l] - shifted;
                        quo_reg[d][l] <= {quo_reg[d-1][l][DIV_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[d][l] <= rem_reg[d-1][l];
                        quo_reg[d][l] <= {quo_reg[d-1][l][DIV_BITS-2:0], 1'b0};
                    end
                    los_reg[d][l] <= los_reg[d-1][l];
                    his_reg[d][l] <= his_reg[d-1][l];
                end
            end
        end
    end

    // clamp quotients and form the vertex
    logic signed [19:0] qq [4];
    rsq_pkg::vtx_t      vtx_next;

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            if (los_reg[DIV_BITS][l])
            begin
                qq[l] = -20'sd32768;
            end
            else if (his_reg[DIV_BITS][l])
            begin
                qq[l] = 20'sd65535;
            end
            else
            begin
                qq[l] = $signed(20'(quo_reg[DIV_BITS][l])) - 20'sd32768;
            end
        end
        vtx_next.corner = ctx_reg[LAST].corner;
        vtx_next.last   = ctx_reg[LAST].corner == rsq_pkg::CORNER_BR;
        vtx_next.pos_x  = sat16(qq[0] - 20'(ONE_Q14));
        vtx_next.pos_y  = sat16(20'(ONE_Q14) - qq[1]);
        vtx_next.tex_u  = sat16(qq[2]);
        vtx_next.tex_v  = sat16(qq[3]);
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= vtx_next;
        end
    end

    assign vtx_valid = out_valid_reg;
    assign vtx_data  = out_data_reg;

    // a new request only lands when the held one is issuing its last vertex
    a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (!hold_reg || (issue && k_reg == rsq_pkg::CORNER_BR)))
        else $error("request accepted while previous one still issuing");

    // an idle front end always restarts at the top-left corner
    a_corner_start: assert property (@(posedge clk) disable iff (!rst_n)
        !hold_reg |-> k_reg == 2'd0)
        else $error("corner counter not at top-left while idle");

    // a held output freezes the whole pipeline
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg) && $stable(k_reg))
        else $error("pipeline moved under output stall");

    // table position remainder is corrected into range
    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[6] |-> (fr7_reg[0] < 11'(QUARTER) && fr7_reg[1] < 11'(QUARTER)))
        else $error("table fraction out of range");

    // divider lanes 0 and 2 never saturate both ways at once
    a_sat_flags: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[DIV0] |-> !(los_reg[0][0] && his_reg[0][0]) && !(los_reg[0][2] && his_reg[0][2]))
        else $error("divider saturation flags conflict");

endmodule

`default_nettype wire
